### rtl/quaternion_vector_rotate_unit_assert.svh
// assertion macros for the quaternion vector rotate unit
// used by quaternion_vector_rotate_unit.sv, expects signals clock and reset in scope
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define QVR_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qvr assertion failed");

// next-cycle implication
`define QVR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qvr assertion failed");

`else

`define QVR_ASSERT_IMPLIES(lbl, ante, cons)
`define QVR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/qvr_pkg.sv
// widths and constants for the quaternion vector rotate unit
// no dependencies
package qvr_pkg;

   // field widths
   localparam int VEC_W  = 24;
   localparam int QUAT_W = 16;

   // quaternion after optional conjugation needs one more bit
   localparam int QN_W   = QUAT_W + 1;

   // first products and first sums (26 fraction bits), exact
   localparam int P1_W   = VEC_W + QN_W;
   localparam int T_W    = 41;
   localparam int S1_W   = T_W + 2;

   // second products and second sums (40 fraction bits), exact
   localparam int P2_W   = T_W + QN_W;
   localparam int R_W    = 58;
   localparam int S2_W   = R_W + 2;

   // rounding to 12 fraction bits
   localparam int RND_SHIFT = 28;
   localparam int RND_W     = R_W + 1;
   localparam int SH_W      = RND_W - RND_SHIFT;

   localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(64'sd1 <<< (RND_SHIFT - 1));
   localparam logic signed [SH_W-1:0]  OUT_MAX  = SH_W'(64'sd8388607);
   localparam logic signed [SH_W-1:0]  OUT_MIN  = SH_W'(-64'sd8388608);
   localparam logic signed [VEC_W-1:0] VEC_MAX  = VEC_W'(64'sd8388607);
   localparam logic signed [VEC_W-1:0] VEC_MIN  = VEC_W'(-64'sd8388608);

   // direction codes
   typedef enum logic {
      CMD_FORWARD = 1'b0,
      CMD_REVERSE = 1'b1
   } cmd_type;

   // result of rounding and clamping one component
   typedef struct packed {
      logic signed [VEC_W-1:0] value;
      logic                    clamped;
   } fin_type;

   // round half up to 12 fraction bits, then clamp to the vector range
   function automatic fin_type finish(input logic signed [R_W-1:0] s);
      logic signed [RND_W-1:0] biased;
      logic signed [RND_W-1:0] shifted;
      logic signed [SH_W-1:0]  r;
      fin_type                 f;
      biased  = RND_W'(s) + RND_HALF;
      shifted = biased >>> RND_SHIFT;
      r       = shifted[SH_W-1:0];
      if (r > OUT_MAX) begin
         f.value   = VEC_MAX;
         f.clamped = 1'b1;
      end else if (r < OUT_MIN) begin
         f.value   = VEC_MIN;
         f.clamped = 1'b1;
      end else begin
         f.value   = r[VEC_W-1:0];
         f.clamped = 1'b0;
      end
      return f;
   endfunction

endpackage

### rtl/quaternion_vector_rotate_unit.sv
// Quaternion rotation of a 3-vector in fixed point.
// A word on the req_ channel carries a command, a Q12.12 vector and a Q1.14
// quaternion. Command 0 returns the vector part of q v q*, command 1 that of
// q* v q. One word leaves on the rsp_ channel per accepted word, in order,
// with the rotated Q12.12 vector and a flag that is set when any component
// was clamped (non-unit quaternion).
// The datapath is a six stage pipeline: input register, first products,
// first sums, second products, second sums, round and clamp. rsp_valid is
// the valid bit of the last stage. Every stage takes a new word each cycle
// while rsp_stall is low, so throughput is one word per cycle.
// Each stage has its own valid bit and advances when it is empty or the
// stage after it advances, so bubbles close up while rsp_stall is high and
// req_stall rises only once all six stages hold a word.
// Reset (synchronous, active high) clears all valid bits; words in flight
// are dropped. A stalled result holds its value until it is taken.
// depends on qvr_pkg and quaternion_vector_rotate_unit_assert.svh
`include "quaternion_vector_rotate_unit_assert.svh"

module quaternion_vector_rotate_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic signed [qvr_pkg::VEC_W-1:0]    req_vec_x,
   input  logic signed [qvr_pkg::VEC_W-1:0]    req_vec_y,
   input  logic signed [qvr_pkg::VEC_W-1:0]    req_vec_z,
   input  logic signed [qvr_pkg::QUAT_W-1:0]   req_quat_w,
   input  logic signed [qvr_pkg::QUAT_W-1:0]   req_quat_x,
   input  logic signed [qvr_pkg::QUAT_W-1:0]   req_quat_y,
   input  logic signed [qvr_pkg::QUAT_W-1:0]   req_quat_z,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [qvr_pkg::VEC_W-1:0]    rsp_out_x,
   output logic signed [qvr_pkg::VEC_W-1:0]    rsp_out_y,
   output logic signed [qvr_pkg::VEC_W-1:0]    rsp_out_z,
   output logic                                rsp_saturated
);
   import qvr_pkg::*;

   // stage valid bits and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   // stage 1: vector and (possibly conjugated) quaternion
   logic signed [VEC_W-1:0] x1_ff, y1_ff, z1_ff;
   logic signed [QN_W-1:0]  w1_ff, a1_ff, b1_ff, c1_ff;
   logic signed [QN_W-1:0]  w1_in, a1_in, b1_in, c1_in;

   // stage 2: first products
   logic signed [P1_W-1:0]  p1_ff [12];
   logic signed [P1_W-1:0]  p1_in [12];
   logic signed [QN_W-1:0]  w2_ff, a2_ff, b2_ff, c2_ff;

   // stage 3: intermediate terms t0..t3
   logic signed [T_W-1:0]   t3_ff [4];
   logic signed [T_W-1:0]   t3_in [4];
   logic signed [S1_W-1:0]  s1_sum [4];
   logic signed [QN_W-1:0]  w3_ff, a3_ff, b3_ff, c3_ff;

   // stage 4: second products
   logic signed [P2_W-1:0]  p2_ff [12];
   logic signed [P2_W-1:0]  p2_in [12];

   // stage 5: second sums
   logic signed [R_W-1:0]   r5_ff [3];
   logic signed [R_W-1:0]   r5_in [3];
   logic signed [S2_W-1:0]  s2_sum [3];

   // stage 6: rounded and clamped result
   fin_type                 fin_x, fin_y, fin_z;
   logic signed [VEC_W-1:0] ox_ff, oy_ff, oz_ff;
   logic                    sat_ff;

   // pipeline advance: a stage moves when empty or when the next one moves
   always_comb begin
      en6 = !v6_ff || !rsp_stall;
      en5 = !v5_ff || en6;
      en4 = !v4_ff || en5;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
   end

   assign req_stall = !en1;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // reverse rotation uses the conjugate: negate the vector part
   always_comb begin
      w1_in = QN_W'(req_quat_w);
      if (cmd_type'(req_command) == CMD_REVERSE) begin
         a1_in = -QN_W'(req_quat_x);
         b1_in = -QN_W'(req_quat_y);
         c1_in = -QN_W'(req_quat_z);
      end else begin
         a1_in = QN_W'(req_quat_x);
         b1_in = QN_W'(req_quat_y);
         c1_in = QN_W'(req_quat_z);
      end
   end

   // first products: q times v
   always_comb begin
      p1_in[0]  = a1_ff * x1_ff;
      p1_in[1]  = b1_ff * y1_ff;
      p1_in[2]  = c1_ff * z1_ff;
      p1_in[3]  = w1_ff * y1_ff;
      p1_in[4]  = a1_ff * z1_ff;
      p1_in[5]  = c1_ff * x1_ff;
      p1_in[6]  = w1_ff * z1_ff;
      p1_in[7]  = a1_ff * y1_ff;
      p1_in[8]  = b1_ff * x1_ff;
      p1_in[9]  = w1_ff * x1_ff;
      p1_in[10] = b1_ff * z1_ff;
      p1_in[11] = c1_ff * y1_ff;
   end

   // first sums, index 0..3 hold t0..t3 (exact, fit in T_W bits)
   always_comb begin
      s1_sum[3] = S1_W'(p1_ff[0]) + S1_W'(p1_ff[1])  + S1_W'(p1_ff[2]);
      s1_sum[0] = S1_W'(p1_ff[3]) - S1_W'(p1_ff[4])  + S1_W'(p1_ff[5]);
      s1_sum[1] = S1_W'(p1_ff[6]) + S1_W'(p1_ff[7])  - S1_W'(p1_ff[8]);
      s1_sum[2] = S1_W'(p1_ff[9]) + S1_W'(p1_ff[10]) - S1_W'(p1_ff[11]);
      for (int i = 0; i < 4; i++) begin
         t3_in[i] = s1_sum[i][T_W-1:0];
      end
   end

   // second products: terms times q
   always_comb begin
      p2_in[0]  = t3_ff[2] * w3_ff;
      p2_in[1]  = t3_ff[3] * a3_ff;
      p2_in[2]  = t3_ff[1] * b3_ff;
      p2_in[3]  = t3_ff[0] * c3_ff;
      p2_in[4]  = t3_ff[0] * w3_ff;
      p2_in[5]  = t3_ff[1] * a3_ff;
      p2_in[6]  = t3_ff[3] * b3_ff;
      p2_in[7]  = t3_ff[2] * c3_ff;
      p2_in[8]  = t3_ff[1] * w3_ff;
      p2_in[9]  = t3_ff[0] * a3_ff;
      p2_in[10] = t3_ff[2] * b3_ff;
      p2_in[11] = t3_ff[3] * c3_ff;
   end

   // second sums (exact, fit in R_W bits)
   always_comb begin
      s2_sum[0] = S2_W'(p2_ff[0]) + S2_W'(p2_ff[1]) + S2_W'(p2_ff[2])
                - S2_W'(p2_ff[3]);
      s2_sum[1] = S2_W'(p2_ff[4]) - S2_W'(p2_ff[5]) + S2_W'(p2_ff[6])
                + S2_W'(p2_ff[7]);
      s2_sum[2] = S2_W'(p2_ff[8]) + S2_W'(p2_ff[9]) - S2_W'(p2_ff[10])
                + S2_W'(p2_ff[11]);
      for (int i = 0; i < 3; i++) begin
         r5_in[i] = s2_sum[i][R_W-1:0];
      end
   end

   // round and clamp
   always_comb begin
      fin_x = finish(r5_ff[0]);
      fin_y = finish(r5_ff[1]);
      fin_z = finish(r5_ff[2]);
   end

   // datapath registers, loaded when their stage advances
   always_ff @(posedge clock) begin
      if (en1) begin
         x1_ff <= req_vec_x;
         y1_ff <= req_vec_y;
         z1_ff <= req_vec_z;
         w1_ff <= w1_in;
         a1_ff <= a1_in;
         b1_ff <= b1_in;
         c1_ff <= c1_in;
      end
      if (en2) begin
         p1_ff <= p1_in;
         w2_ff <= w1_ff;
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
         c2_ff <= c1_ff;
      end
      if (en3) begin
         t3_ff <= t3_in;
         w3_ff <= w2_ff;
         a3_ff <= a2_ff;
         b3_ff <= b2_ff;
         c3_ff <= c2_ff;
      end
      if (en4) begin
         p2_ff <= p2_in;
      end
      if (en5) begin
         r5_ff <= r5_in;
      end
      if (en6) begin
         ox_ff  <= fin_x.value;
         oy_ff  <= fin_y.value;
         oz_ff  <= fin_z.value;
         sat_ff <= fin_x.clamped | fin_y.clamped | fin_z.clamped;
      end
   end

   // response outputs
   assign rsp_valid     = v6_ff;
   assign rsp_out_x     = ox_ff;
   assign rsp_out_y     = oy_ff;
   assign rsp_out_z     = oz_ff;
   assign rsp_saturated = sat_ff;

   // input is held back only when stages 1, 5 and 6 are full and the output is stalled
   `QVR_ASSERT_IMPLIES(a_stall_only_when_full,
      req_stall, rsp_valid && rsp_stall && v1_ff && v5_ff)

   // a full stage 5 that advances always shows up on the output
   `QVR_ASSERT_NEXT(a_stage5_reaches_output, v5_ff && en6, rsp_valid)

   // a flagged result sits on a bound in at least one component
   `QVR_ASSERT_IMPLIES(a_sat_on_bound,
      rsp_valid && rsp_saturated,
      rsp_out_x == VEC_MAX || rsp_out_x == VEC_MIN ||
      rsp_out_y == VEC_MAX || rsp_out_y == VEC_MIN ||
      rsp_out_z == VEC_MAX || rsp_out_z == VEC_MIN)

endmodule

### sim/quaternion_vector_rotate_unit_test.sv
// self-checking testbench for the quaternion vector rotate unit
// predicts every rotated vector in a scoreboard class and compares it with the rsp_ words
// depends on qvr_pkg and quaternion_vector_rotate_unit
module quaternion_vector_rotate_unit_test;
   import qvr_pkg::*;

   localparam int RANDOM_WORDS   = 1600;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_CYCLES    = 250;
   localparam int HOLD_AT_RESULT = 300;
   localparam int MODE_RUN       = 64;

   localparam logic signed [QUAT_W-1:0] QUAT_TOP    = 16'sh7fff;
   localparam logic signed [QUAT_W-1:0] QUAT_BOTTOM = 16'sh8000;
   localparam logic signed [QUAT_W-1:0] QUAT_ONE    = 16'sh4000;

   typedef enum int {
      IDLE_RANDOM,
      IDLE_NONE,
      IDLE_SPARSE
   } idle_mode_type;

   typedef struct {
      cmd_type                  cmd;
      logic signed [VEC_W-1:0]  vx, vy, vz;
      logic signed [QUAT_W-1:0] qw, qx, qy, qz;
   } rotate_req_type;

   typedef struct {
      logic signed [VEC_W-1:0] x, y, z;
      logic                    sat;
   } rotated_vec_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_command;
   logic signed [VEC_W-1:0]   req_vec_x, req_vec_y, req_vec_z;
   logic signed [QUAT_W-1:0]  req_quat_w, req_quat_x, req_quat_y, req_quat_z;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [VEC_W-1:0]   rsp_out_x, rsp_out_y, rsp_out_z;
   logic                      rsp_saturated;
   int                        cycle_count = 0;

   // expected rotated vectors, oldest first
   class rotation_scoreboard;
      rotated_vec_type expected_rotations[$];
      int              error_count;

      function new();
         error_count = 0;
      endfunction

      // round 40 fraction bits to 12 (half up), clamp to the vector range
      function logic signed [VEC_W-1:0] round_clamp(input longint s, inout logic sat);
         longint r;
         r = (s + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
         if (r > longint'(VEC_MAX)) begin
            sat = 1'b1;
            return VEC_MAX;
         end
         if (r < longint'(VEC_MIN)) begin
            sat = 1'b1;
            return VEC_MIN;
         end
         return VEC_W'(r);
      endfunction

      function rotated_vec_type predict_rotation(rotate_req_type rq);
         longint          x, y, z, w, a, b, c;
         longint          t0, t1, t2, t3, rx, ry, rz;
         logic            sat;
         rotated_vec_type p;
         x = rq.vx;
         y = rq.vy;
         z = rq.vz;
         w = rq.qw;
         a = rq.qx;
         b = rq.qy;
         c = rq.qz;
         // first product with q (forward) or q* (reverse), then the second one
         t3 = a * x + b * y + c * z;
         if (rq.cmd == CMD_FORWARD) begin
            t0 = w * y - a * z + c * x;
            t1 = w * z + a * y - b * x;
            t2 = w * x + b * z - c * y;
            rx = t2 * w + t3 * a + t1 * b - t0 * c;
            ry = t0 * w - t1 * a + t3 * b + t2 * c;
            rz = t1 * w + t0 * a - t2 * b + t3 * c;
         end else begin
            t0 = w * y + a * z - c * x;
            t1 = w * z - a * y + b * x;
            t2 = w * x - b * z + c * y;
            rx = t2 * w + t3 * a - t1 * b + t0 * c;
            ry = t0 * w + t1 * a + t3 * b - t2 * c;
            rz = t1 * w - t0 * a + t2 * b + t3 * c;
         end
         sat   = 1'b0;
         p.x   = round_clamp(rx, sat);
         p.y   = round_clamp(ry, sat);
         p.z   = round_clamp(rz, sat);
         p.sat = sat;
         return p;
      endfunction

      function void note_request(rotate_req_type rq);
         expected_rotations.push_back(predict_rotation(rq));
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(rotated_vec_type got);
         rotated_vec_type want;
         if (expected_rotations.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, expected none, actual %0d %0d %0d sat %0d",
                     $time, got.x, got.y, got.z, got.sat);
            return;
         end
         want = expected_rotations.pop_front();
         compare_field("out_x", want.x, got.x);
         compare_field("out_y", want.y, got.y);
         compare_field("out_z", want.z, got.z);
         compare_field("saturated", want.sat, got.sat);
      endfunction

      function int pending();
         return expected_rotations.size();
      endfunction
   endclass

   rotation_scoreboard scoreboard;

   quaternion_vector_rotate_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .req_quat_w    (req_quat_w),
      .req_quat_x    (req_quat_x),
      .req_quat_y    (req_quat_y),
      .req_quat_z    (req_quat_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_saturated (rsp_saturated)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // observe both channels at the clock edge
   always @(posedge clock) begin
      rotate_req_type  seen_req;
      rotated_vec_type seen_rsp;
      if (!reset && req_valid && !req_stall) begin
         seen_req.cmd = cmd_type'(req_command);
         seen_req.vx  = req_vec_x;
         seen_req.vy  = req_vec_y;
         seen_req.vz  = req_vec_z;
         seen_req.qw  = req_quat_w;
         seen_req.qx  = req_quat_x;
         seen_req.qy  = req_quat_y;
         seen_req.qz  = req_quat_z;
         scoreboard.note_request(seen_req);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_rsp.x   = rsp_out_x;
         seen_rsp.y   = rsp_out_y;
         seen_rsp.z   = rsp_out_z;
         seen_rsp.sat = rsp_saturated;
         scoreboard.check_result(seen_rsp);
      end
   end

   function automatic int draw_wait(idle_mode_type mode);
      case (mode)
         IDLE_NONE:   return 0;
         IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 15)) : 0;
         default:     return $urandom_range(0, 15);
      endcase
   endfunction

   function automatic rotate_req_type word_of(cmd_type cmd, int vx, int vy, int vz,
                                              int qw, int qx, int qy, int qz);
      rotate_req_type rq;
      rq.cmd = cmd;
      rq.vx  = VEC_W'(vx);
      rq.vy  = VEC_W'(vy);
      rq.vz  = VEC_W'(vz);
      rq.qw  = QUAT_W'(qw);
      rq.qx  = QUAT_W'(qx);
      rq.qy  = QUAT_W'(qy);
      rq.qz  = QUAT_W'(qz);
      return rq;
   endfunction

   function automatic logic signed [VEC_W-1:0] vec_corner();
      case ($urandom_range(0, 4))
         0:       return VEC_MAX;
         1:       return VEC_MIN;
         2:       return '0;
         3:       return 24'sd1;
         default: return -24'sd1;
      endcase
   endfunction

   function automatic logic signed [QUAT_W-1:0] quat_corner();
      case ($urandom_range(0, 4))
         0:       return QUAT_TOP;
         1:       return QUAT_BOTTOM;
         2:       return '0;
         3:       return QUAT_ONE;
         default: return -QUAT_ONE;
      endcase
   endfunction

   // mostly unit quaternions, most with sensible vectors, then raw noise and corners
   function automatic rotate_req_type random_word();
      rotate_req_type rq;
      int             kind;
      int             c[4];
      real            norm;
      rq.cmd = cmd_type'($urandom_range(0, 1));
      kind   = $urandom_range(0, 99);
      if (kind < 65) begin
         for (int i = 0; i < 4; i++) c[i] = int'($urandom_range(0, 32768)) - 16384;
         norm = $sqrt(real'(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]));
         if (norm < 64.0) begin
            rq.qw = QUAT_ONE;
            rq.qx = '0;
            rq.qy = '0;
            rq.qz = '0;
         end else begin
            rq.qw = QUAT_W'($rtoi(c[0] * 16384.0 / norm));
            rq.qx = QUAT_W'($rtoi(c[1] * 16384.0 / norm));
            rq.qy = QUAT_W'($rtoi(c[2] * 16384.0 / norm));
            rq.qz = QUAT_W'($rtoi(c[3] * 16384.0 / norm));
         end
         if (kind < 50) begin
            rq.vx = VEC_W'(int'($urandom_range(0, 2097152)) - 1048576);
            rq.vy = VEC_W'(int'($urandom_range(0, 2097152)) - 1048576);
            rq.vz = VEC_W'(int'($urandom_range(0, 2097152)) - 1048576);
         end else begin
            rq.vx = VEC_W'($urandom);
            rq.vy = VEC_W'($urandom);
            rq.vz = VEC_W'($urandom);
         end
      end else if (kind < 90) begin
         rq.vx = VEC_W'($urandom);
         rq.vy = VEC_W'($urandom);
         rq.vz = VEC_W'($urandom);
         rq.qw = QUAT_W'($urandom);
         rq.qx = QUAT_W'($urandom);
         rq.qy = QUAT_W'($urandom);
         rq.qz = QUAT_W'($urandom);
      end else begin
         rq.vx = vec_corner();
         rq.vy = vec_corner();
         rq.vz = vec_corner();
         rq.qw = quat_corner();
         rq.qx = quat_corner();
         rq.qy = quat_corner();
         rq.qz = quat_corner();
      end
      return rq;
   endfunction

   // offer one word after an idle gap, hold it until accepted
   task automatic send_word(input rotate_req_type rq, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= rq.cmd;
      req_vec_x   <= rq.vx;
      req_vec_y   <= rq.vy;
      req_vec_z   <= rq.vz;
      req_quat_w  <= rq.qw;
      req_quat_x  <= rq.qx;
      req_quat_y  <= rq.qy;
      req_quat_z  <= rq.qz;
      do @(posedge clock); while (req_stall);
   endtask

   // result side: random stalls per word, one long hold-off to back up the pipeline
   initial begin
      int            accepted;
      int            hold;
      idle_mode_type mode;
      accepted  = 0;
      mode      = IDLE_RANDOM;
      rsp_stall = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (accepted % 50 == 0) mode = idle_mode_type'($urandom_range(0, 2));
         hold = (accepted == HOLD_AT_RESULT) ? HOLD_CYCLES : draw_wait(mode);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            for (int i = 0; i < hold; i++) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         accepted++;
      end
   end

   // stimulus and end of run
   initial begin
      idle_mode_type mode;
      scoreboard  = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = CMD_FORWARD;
      req_vec_x   = '0;
      req_vec_y   = '0;
      req_vec_z   = '0;
      req_quat_w  = '0;
      req_quat_x  = '0;
      req_quat_y  = '0;
      req_quat_z  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // identity, quarter turns and a third of a turn about the diagonal, in both directions
      send_word(word_of(CMD_FORWARD, 4096, 8192, -12288, QUAT_ONE, 0, 0, 0), draw_wait(IDLE_RANDOM));
      send_word(word_of(CMD_REVERSE, 4096, 8192, -12288, QUAT_ONE, 0, 0, 0), draw_wait(IDLE_RANDOM));
      send_word(word_of(CMD_FORWARD, 4096, 0, 0, 11585, 0, 0, 11585), draw_wait(IDLE_RANDOM));
      send_word(word_of(CMD_REVERSE, 4096, 0, 0, 11585, 0, 0, 11585), draw_wait(IDLE_RANDOM));
      send_word(word_of(CMD_FORWARD, 4096, 8192, 12288, 8192, 8192, 8192, 8192), draw_wait(IDLE_RANDOM));
      send_word(word_of(CMD_REVERSE, 4096, 8192, 12288, 8192, 8192, 8192, 8192), draw_wait(IDLE_RANDOM));
      // vector extremes under the identity, all zero
      send_word(word_of(CMD_FORWARD, VEC_MAX, VEC_MAX, VEC_MAX, QUAT_ONE, 0, 0, 0), 0);
      send_word(word_of(CMD_REVERSE, VEC_MIN, VEC_MIN, VEC_MIN, QUAT_ONE, 0, 0, 0), 0);
      send_word(word_of(CMD_FORWARD, 0, 0, 0, 0, 0, 0, 0), 0);
      // half-turns about single axes
      send_word(word_of(CMD_REVERSE, 1, -1, VEC_MAX, 0, QUAT_ONE, 0, 0), draw_wait(IDLE_RANDOM));
      send_word(word_of(CMD_FORWARD, VEC_MIN, 2, 3, 0, 0, -QUAT_ONE, 0), draw_wait(IDLE_RANDOM));
      // exact half rounding, up and toward plus infinity
      send_word(word_of(CMD_FORWARD, 2, -2, 6, 8192, 0, 0, 0), draw_wait(IDLE_RANDOM));
      send_word(word_of(CMD_REVERSE, -6, 2, -2, 8192, 0, 0, 0), draw_wait(IDLE_RANDOM));
      // non-unit quaternions that push the result out of range
      send_word(word_of(CMD_FORWARD, VEC_MAX, VEC_MAX, VEC_MAX,
                        QUAT_TOP, QUAT_TOP, QUAT_TOP, QUAT_TOP), 0);
      send_word(word_of(CMD_REVERSE, VEC_MIN, VEC_MIN, VEC_MIN,
                        QUAT_BOTTOM, QUAT_BOTTOM, QUAT_BOTTOM, QUAT_BOTTOM), 0);
      send_word(word_of(CMD_FORWARD, VEC_MAX, VEC_MIN, 1, QUAT_BOTTOM, 0, 0, 0), 0);
      send_word(word_of(CMD_REVERSE, VEC_MAX, VEC_MIN, VEC_MAX,
                        QUAT_TOP, QUAT_BOTTOM, QUAT_TOP, QUAT_BOTTOM), draw_wait(IDLE_RANDOM));
      send_word(word_of(CMD_FORWARD, VEC_MAX, VEC_MAX, VEC_MAX,
                        QUAT_BOTTOM, QUAT_BOTTOM, QUAT_BOTTOM, QUAT_BOTTOM), draw_wait(IDLE_RANDOM));

      // random words, idle pattern changes every run of words
      mode = IDLE_RANDOM;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % MODE_RUN == 0) mode = idle_mode_type'($urandom_range(0, 2));
         send_word(random_word(), draw_wait(mode));
      end
      req_valid <= 1'b0;

      // drain the pipeline
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.error_count == 0 && scoreboard.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate_unit.sv
sim/quaternion_vector_rotate_unit_test.sv
